// File: hw/rtl/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url encoder package
// Beat types, the work descriptor passed from front to back, and the
// sextet-to-character mapping shared by the encoder modules.
// ----------------------------------------------------------------------------
package b64u_pkg;

	// Default depth of the descriptor queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned SEXTET_W = 6;

	// Position of the next byte within its three-byte group.
	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD  = 2'd2
	} group_pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_beat_t;

	// One byte's worth of work: one or two sextets. The first sextet is never
	// the end of a message; last applies to the second one only.
	typedef struct packed {
		logic [SEXTET_W-1:0] sx0;
		logic [SEXTET_W-1:0] sx1;
		logic                two;
		logic                last;
	} job_t;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_DASH    = 8'h2D;
	localparam logic [7:0] ASCII_UNDER   = 8'h5F;

	// Maps a sextet onto the URL-safe alphabet A-Z a-z 0-9 - _.
	function automatic logic [7:0] sextet_to_char(input logic [SEXTET_W-1:0] sx);
		logic [7:0] s;
		s = {2'b00, sx};
		if (sx < 6'd26) begin
			return s + ASCII_UPPER_A;
		end else if (sx < 6'd52) begin
			return s - 8'd26 + ASCII_LOWER_A;
		end else if (sx < 6'd62) begin
			return s - 8'd52 + ASCII_ZERO;
		end else if (sx == 6'd62) begin
			return ASCII_DASH;
		end else begin
			return ASCII_UNDER;
		end
	endfunction

endpackage

// File: hw/rtl/base64url_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url stream encoder (unpadded)
// Encodes a byte stream into URL-safe base64 characters with no padding.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat        | Fields
//   --------+-----------+-------------+------------------------------
//   byte    | in        | in_beat_t   | data_byte[7:0], final_byte
//   char    | out       | out_beat_t  | out_char[7:0], out_last
//
// The back end sends a single character per cycle from its output register
// while char_stall is low, so a byte that yields two characters holds it
// longer than a byte that yields one. An accepted byte is first written into
// the queue, and its first character is then loaded into the output register.
// Reset clears the group position, queue and output valid; no clearing pass
// is needed. The front raises byte_stall only when the queue is full, which
// happens when the character channel is stalled or when bytes that yield two
// characters arrive faster than the back end can send their characters.
//
// The front end keeps the group position and leftover bits and turns each
// byte into a descriptor of one or two sextets. The queue between front and
// back lets the front take a new byte while the back is still emitting the
// second character of an earlier one.
module base64url_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  b64u_pkg::in_beat_t  byte_beat,
	output logic                char_valid,
	input  logic                char_stall,
	output b64u_pkg::out_beat_t char_beat
);
	import b64u_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Front end: classifies each byte by its position in the group.
	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	// Descriptor queue decoupling the two halves.
	b64u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: serialises sextets into characters.
	b64u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head_job),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

endmodule

// File: hw/rtl/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url encoder front end
// Accepts bytes, tracks the group position and leftover bits, and turns each
// byte into a descriptor of one or two sextets for the queue.
// ----------------------------------------------------------------------------
module b64u_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  b64u_pkg::in_beat_t byte_beat,
	input  logic               q_full,
	output logic               push,
	output b64u_pkg::job_t     job
);
	import b64u_pkg::*;

	group_pos_t pos_q;
	logic [3:0] left_q;
	group_pos_t pos_next;
	logic [3:0] left_next;
	logic [7:0] b;
	logic       fin;

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;
	assign b          = byte_beat.data_byte;
	assign fin        = byte_beat.final_byte;

	always_comb begin
		job       = '0;
		pos_next  = POS_FIRST;
		left_next = 4'd0;
		unique case (pos_q)
			POS_SECOND: begin
				job.sx0 = {left_q[1:0], b[7:4]};
				if (fin) begin
					job.sx1  = {b[3:0], 2'b00};
					job.two  = 1'b1;
					job.last = 1'b1;
				end else begin
					pos_next  = POS_THIRD;
					left_next = b[3:0];
				end
			end
			POS_THIRD: begin
				job.sx0  = {left_q, b[7:6]};
				job.sx1  = b[5:0];
				job.two  = 1'b1;
				job.last = fin;
			end
			default: begin
				job.sx0 = b[7:2];
				if (fin) begin
					job.sx1  = {b[1:0], 4'b0000};
					job.two  = 1'b1;
					job.last = 1'b1;
				end else begin
					pos_next  = POS_SECOND;
					left_next = {2'b00, b[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_FIRST;
			left_q <= 4'd0;
		end else if (push) begin
			pos_q  <= pos_next;
			left_q <= left_next;
		end
	end

endmodule

// File: hw/rtl/b64u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url encoder descriptor queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module b64u_queue #(
	parameter int unsigned DEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64u_pkg::job_t wr_job,
	input  logic           pop,
	output b64u_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);
	import b64u_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: hw/rtl/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url encoder back end
// Pops descriptors, maps sextets to characters and serialises them into the
// output register, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module b64u_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  b64u_pkg::job_t      head,
	output logic                pop,
	output logic                char_valid,
	input  logic                char_stall,
	output b64u_pkg::out_beat_t char_beat
);
	import b64u_pkg::*;

	logic                out_valid_q;
	out_beat_t           out_beat_q;
	logic                pend_q;
	logic [SEXTET_W-1:0] pend_sx_q;
	logic                pend_last_q;
	logic                load;

	assign load       = !out_valid_q || !char_stall;
	assign pop        = load && !pend_q && !q_empty;
	assign char_valid = out_valid_q;
	assign char_beat  = out_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= head.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_beat_q.out_char <= sextet_to_char(pend_sx_q);
				out_beat_q.out_last <= pend_last_q;
			end else if (!q_empty) begin
				out_beat_q.out_char <= sextet_to_char(head.sx0);
				out_beat_q.out_last <= 1'b0;
				pend_sx_q           <= head.sx1;
				pend_last_q         <= head.last;
			end
		end
	end

endmodule

// File: hw/rtl/b64u_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64url encoder port checker
// Concurrent checks on the encoder's ports, bound to the top level.
// ----------------------------------------------------------------------------
module b64u_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input b64u_pkg::in_beat_t  byte_beat,
	input logic                char_valid,
	input logic                char_stall,
	input b64u_pkg::out_beat_t char_beat
);
	import b64u_pkg::*;

	// A held character beat must not change or vanish.
	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(char_beat))
		else $error("character beat changed while stalled");

	// Every character sent belongs to the URL-safe alphabet.
	a_char_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |->
			(char_beat.out_char >= 8'h41 && char_beat.out_char <= 8'h5A) ||
			(char_beat.out_char >= 8'h61 && char_beat.out_char <= 8'h7A) ||
			(char_beat.out_char >= 8'h30 && char_beat.out_char <= 8'h39) ||
			(char_beat.out_char == 8'h2D) || (char_beat.out_char == 8'h5F))
		else $error("character outside base64url alphabet");

	// The byte side is only held back when characters are waiting to leave.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> char_valid)
		else $error("byte channel stalled with no character pending");

	// A final byte that is accepted with an idle output produces a character
	// once it has passed the queue and the output register.
	a_accept_emits: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && byte_beat.final_byte && !char_valid
			|=> ##1 char_valid)
		else $error("accepted byte produced no character");

endmodule

bind base64url_stream_encoder b64u_checker u_b64u_checker (.*);

// File: test/tb_base64url_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the base64url stream encoder
// Drives byte beats, grouped into messages, through the encoder and checks
// every character beat against the table's expectations or a predictor of
// unpadded base64url encoding. A short table of directed bytes comes first,
// then random messages.
module tb_base64url_stream_encoder;

	import b64u_pkg::*;

	// Length of the long receiver hold-off that fills the encoder up.
	localparam int unsigned LONG_HOLD    = 300;
	// The random part stops once this many bytes have been accepted.
	localparam int unsigned TARGET_BYTES = 1600;
	// From this many bytes onwards neither side idles any more.
	localparam int unsigned CALM_FROM    = 1350;
	// The long hold-off starts once this many bytes have gone in.
	localparam int unsigned HOLD_FROM    = 400;
	localparam int unsigned DIR_ROWS     = 22;

	// The URL-safe alphabet, first character in the top byte.
	localparam logic [8*64-1:0] URL_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	// One row of the directed table. Where typed is non-zero the row carries
	// that many expected character beats of its own; otherwise the
	// predictor supplies them.
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic [1:0] typed;
		out_beat_t  e0;
		out_beat_t  e1;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_beat_t  byte_beat;
	logic      char_valid;
	logic      char_stall;
	out_beat_t char_beat;

	// Character beats that the encoder still owes, oldest first.
	out_beat_t pending_chars[$];

	// Predictor state: where the next byte falls in its group of three, and
	// the bits of earlier bytes that do not yet fill a sextet.
	group_pos_t grp_pos;
	logic [3:0] held_bits;

	int unsigned mismatch_count;
	int unsigned bytes_sent;
	bit          gaps_on;
	bit          hold_chars;
	bit          pressure_done;

	dir_row_t dir_rows [DIR_ROWS];

	base64url_stream_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Looks a sextet up in the alphabet.
	function automatic logic [7:0] url_char(input logic [5:0] sx);
		return URL_ALPHABET[8*(63-sx) +: 8];
	endfunction

	// Encodes one byte: returns the one or two character beats it completes
	// and moves the group position and held bits on. A final byte flushes
	// any partial sextet with zero fill and closes the message.
	task automatic encode_byte(input logic [7:0] d, input logic fin,
			output out_beat_t c0, output out_beat_t c1, output int n);
		c1 = '0;
		case (grp_pos)
			POS_SECOND: begin
				c0 = '{url_char({held_bits[1:0], d[7:4]}), 1'b0};
				if (fin) begin
					c1 = '{url_char({d[3:0], 2'b00}), 1'b1};
					n = 2;
					grp_pos = POS_FIRST;
					held_bits = '0;
				end else begin
					n = 1;
					grp_pos = POS_THIRD;
					held_bits = d[3:0];
				end
			end
			POS_THIRD: begin
				// The third byte always closes the group with two characters.
				c0 = '{url_char({held_bits, d[7:6]}), 1'b0};
				c1 = '{url_char(d[5:0]), fin};
				n = 2;
				grp_pos = POS_FIRST;
				held_bits = '0;
			end
			default: begin
				c0 = '{url_char(d[7:2]), 1'b0};
				if (fin) begin
					c1 = '{url_char({d[1:0], 4'b0000}), 1'b1};
					n = 2;
					grp_pos = POS_FIRST;
					held_bits = '0;
				end else begin
					n = 1;
					grp_pos = POS_SECOND;
					held_bits = {2'b00, d[1:0]};
				end
			end
		endcase
	endtask

	// Offers one byte beat and waits for the encoder to take it. Entered and
	// left at a falling edge; that edge carries at most one assignment to
	// byte_valid, so a valid that stays high is never dropped and raised in
	// the same step. Once the beat is taken the expected characters join
	// the queue, either typed in by the caller or from the predictor.
	task automatic drive_byte(input logic [7:0] d, input logic fin,
			input logic [1:0] typed, input out_beat_t t0, input out_beat_t t1);
		out_beat_t c0;
		out_beat_t c1;
		int        n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= '{d, fin};
		do begin
			@(posedge clk);
		end while (byte_stall);
		bytes_sent++;
		encode_byte(d, fin, c0, c1, n);
		if (typed != 0) begin
			pending_chars.push_back(t0);
			if (typed > 1) begin
				pending_chars.push_back(t1);
			end
		end else begin
			pending_chars.push_back(c0);
			if (n > 1) begin
				pending_chars.push_back(c1);
			end
		end
		@(negedge clk);
	endtask

	// Receiver: random stall bursts while gaps are allowed, runs with no
	// stall in between, and one long hold-off on request. Each branch makes
	// one assignment and then lets at least one falling edge pass.
	initial begin : char_receiver
		char_stall = 1'b0;
		forever begin
			if (hold_chars) begin
				char_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_chars = 1'b0;
			end else if (gaps_on && $urandom_range(0, 2) == 0) begin
				char_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end else begin
				char_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// Checks every character beat taken off the output against the oldest
	// expectation, field by field.
	always @(posedge clk) begin : char_checker
		out_beat_t want;
		if (arst_n && char_valid && !char_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character beat: out_char %h out_last %b",
					char_beat.out_char, char_beat.out_last);
				mismatch_count++;
			end else begin
				want = pending_chars.pop_front();
				if (char_beat.out_char !== want.out_char) begin
					$error("out_char: expected %h, got %h",
						want.out_char, char_beat.out_char);
					mismatch_count++;
				end
				if (char_beat.out_last !== want.out_last) begin
					$error("out_last: expected %b, got %b",
						want.out_last, char_beat.out_last);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random messages with the
	// long hold-off somewhere in the middle and a calm stretch at the end.
	initial begin : byte_sender
		int          msg_len;
		int          pick;
		logic [7:0]  d;
		arst_n         = 1'b0;
		byte_valid     = 1'b0;
		byte_beat      = '0;
		gaps_on        = 1'b1;
		hold_chars     = 1'b0;
		pressure_done  = 1'b0;
		mismatch_count = 0;
		bytes_sent     = 0;
		grp_pos        = POS_FIRST;
		held_bits      = '0;

		dir_rows = '{
			// Single zero byte straight after reset, then a single all-ones byte.
			'{8'h00, 1'b1, 2'd2, '{"A", 1'b0}, '{"A", 1'b1}},
			'{8'hFF, 1'b1, 2'd2, '{"_", 1'b0}, '{"w", 1'b1}},
			// A full group of all-ones bytes: every sextet is the top one.
			'{8'hFF, 1'b0, 2'd1, '{"_", 1'b0}, '0},
			'{8'hFF, 1'b0, 2'd1, '{"_", 1'b0}, '0},
			'{8'hFF, 1'b1, 2'd2, '{"_", 1'b0}, '{"_", 1'b1}},
			// A full group of zero bytes.
			'{8'h00, 1'b0, 2'd1, '{"A", 1'b0}, '0},
			'{8'h00, 1'b0, 2'd1, '{"A", 1'b0}, '0},
			'{8'h00, 1'b1, 2'd2, '{"A", 1'b0}, '{"A", 1'b1}},
			// Two bytes giving the dash, the underscore and a digit.
			'{8'hFB, 1'b0, 2'd1, '{"-", 1'b0}, '0},
			'{8'hFF, 1'b1, 2'd2, '{"_", 1'b0}, '{"8", 1'b1}},
			// Five bytes: one whole group, then a two-byte tail.
			'{8'h4D, 1'b0, 2'd0, '0, '0},
			'{8'h61, 1'b0, 2'd0, '0, '0},
			'{8'h6E, 1'b0, 2'd0, '0, '0},
			'{8'h4D, 1'b0, 2'd0, '0, '0},
			'{8'h61, 1'b1, 2'd0, '0, '0},
			// Four bytes: one whole group, then a one-byte tail.
			'{8'h80, 1'b0, 2'd0, '0, '0},
			'{8'h01, 1'b0, 2'd0, '0, '0},
			'{8'h7F, 1'b0, 2'd0, '0, '0},
			'{8'hFE, 1'b1, 2'd0, '0, '0},
			// Alternating bit patterns, and a lone byte message.
			'{8'h55, 1'b0, 2'd0, '0, '0},
			'{8'hAA, 1'b1, 2'd0, '0, '0},
			'{8'h3C, 1'b1, 2'd0, '0, '0}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			drive_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].e0, dir_rows[i].e1);
		end

		// Random messages, mostly short so that every tail length comes up
		// often, now and then a long one.
		while (bytes_sent < TARGET_BYTES) begin
			if (!pressure_done && bytes_sent >= HOLD_FROM) begin
				// The receiver holds off while bytes keep coming, so the
				// queue fills and byte_stall has to rise.
				hold_chars    = 1'b1;
				pressure_done = 1'b1;
			end
			if (bytes_sent >= CALM_FROM) begin
				gaps_on = 1'b0;
			end
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				msg_len = $urandom_range(1, 6);
			end else if (pick < 9) begin
				msg_len = $urandom_range(7, 24);
			end else begin
				msg_len = $urandom_range(25, 60);
			end
			for (int k = 0; k < msg_len; k++) begin
				pick = $urandom_range(0, 7);
				if (pick == 0) begin
					d = 8'h00;
				end else if (pick == 1) begin
					d = 8'hFF;
				end else begin
					d = 8'($urandom_range(0, 255));
				end
				drive_byte(d, k == msg_len - 1, 2'd0, '0, '0);
			end
		end
		byte_valid <= 1'b0;

		// Let the encoder drain, then keep watching the output so that any stray
		// beat would still be caught.
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && pending_chars.size() == 0) begin
			$display("tb_base64url_stream_encoder: clean");
		end else begin
			$display("tb_base64url_stream_encoder: errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, in which every byte gives
	// two characters and both sides idle as much as they may.
	initial begin : watchdog
		#4_000_000;
		$display("tb_base64url_stream_encoder: errors");
		$finish;
	end

endmodule

// File: base64url_stream_encoder.f
hw/rtl/b64u_pkg.sv
hw/rtl/b64u_front.sv
hw/rtl/b64u_queue.sv
hw/rtl/b64u_back.sv
hw/rtl/base64url_stream_encoder.sv
hw/rtl/b64u_checker.sv
test/tb_base64url_stream_encoder.sv
